// File: design/wvpd_pkg.sv
// ----------------------------------------------------------------------------
// wvpd_pkg
// Shared constants and types for the winding voltage to PWM duty converter.
// ----------------------------------------------------------------------------
`default_nettype none

package wvpd_pkg;

    // Default field widths.
    localparam int VOLT_BITS_DEF = 24;
    localparam int DUTY_BITS_DEF = 15;

    // Configuration register index width and reset values.
    localparam int CFG_INDEX_BITS   = 1;
    localparam int FULL_SCALE_RESET = 2000;
    localparam int MINIMUM_RESET    = 0;

    // Configuration register map.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FULL_SCALE = 1'b0,
        REG_MINIMUM    = 1'b1
    } cfg_reg_t;

endpackage : wvpd_pkg

`default_nettype wire

// File: design/wvpd_in_if.sv
// ----------------------------------------------------------------------------
// wvpd_in_if
// Input channel: voltage demand and measured bus voltage, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvpd_in_if #(
    parameter int VOLT_BITS = wvpd_pkg::VOLT_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [VOLT_BITS-1:0] voltage_demand;
    logic        [VOLT_BITS-2:0] bus_voltage;

    modport source (output valid, output voltage_demand, output bus_voltage, input ready);
    modport sink   (input valid, input voltage_demand, input bus_voltage, output ready);
endinterface : wvpd_in_if

`default_nettype wire

// File: design/wvpd_out_if.sv
// ----------------------------------------------------------------------------
// wvpd_out_if
// Output channel: duty magnitude and drive direction, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvpd_out_if #(
    parameter int DUTY_BITS = wvpd_pkg::DUTY_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] duty_magnitude;
    logic                 reverse_drive;

    modport source (output valid, output duty_magnitude, output reverse_drive, input ready);
    modport sink   (input valid, input duty_magnitude, input reverse_drive, output ready);
endinterface : wvpd_out_if

`default_nettype wire

// File: design/wvpd_cfg_if.sv
// ----------------------------------------------------------------------------
// wvpd_cfg_if
// Configuration write channel: register index and write data, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvpd_cfg_if #(
    parameter int DUTY_BITS = wvpd_pkg::DUTY_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic [wvpd_pkg::CFG_INDEX_BITS-1:0] index;
    logic [DUTY_BITS-1:0]                data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : wvpd_cfg_if

`default_nettype wire

// File: design/winding_voltage_to_pwm_duty.sv
// ----------------------------------------------------------------------------
// winding_voltage_to_pwm_duty
// Converts a signed winding voltage demand into an H-bridge PWM duty count
// and a drive direction, scaled against the measured DC bus voltage.
// ----------------------------------------------------------------------------
//
//  Channel  Role    Payload                                   Transfer
//  -------  ------  ----------------------------------------  ----------------
//  sample   sink    voltage_demand (s), bus_voltage (u)       valid && ready
//  duty     source  duty_magnitude, reverse_drive             valid && ready
//  cfg      sink    index, data                               valid && ready
//
//  The pipeline has one stage for the clamp, one for the multiply, one per
//  quotient bit of the restoring divider, and one for the output stage. One
//  transfer is taken per cycle while the duty channel does not stall.
//  Each stage holds its own valid bit, so bubbles close up under a stall and
//  nothing is dropped or repeated. Reset clears all valid bits and loads the
//  configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module winding_voltage_to_pwm_duty #(
    parameter int VOLT_BITS = wvpd_pkg::VOLT_BITS_DEF,
    parameter int DUTY_BITS = wvpd_pkg::DUTY_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wvpd_in_if.sink   sample,
    wvpd_out_if.source duty,
    wvpd_cfg_if.sink  cfg
);
    localparam int PROD_W = VOLT_BITS + DUTY_BITS - 1;

    // Configuration registers. The user must write them only while the pipeline
    // is idle, since the stages read them live; the block does not enforce it.
    logic [DUTY_BITS-1:0] full_scale_reg;
    logic [DUTY_BITS-1:0] minimum_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_scale_reg <= DUTY_BITS'(wvpd_pkg::FULL_SCALE_RESET);
            minimum_reg    <= DUTY_BITS'(wvpd_pkg::MINIMUM_RESET);
        end
        else if (cfg.valid)
        begin
            case (wvpd_pkg::cfg_reg_t'(cfg.index))
                wvpd_pkg::REG_FULL_SCALE: full_scale_reg <= cfg.data;
                wvpd_pkg::REG_MINIMUM:    minimum_reg    <= cfg.data;
                default:                  ;
            endcase
        end
    end

    // Front end: clamp the demand magnitude to the bus, then multiply by the
    // full-scale count.
    logic              f_valid;
    logic              f_ready;
    logic [PROD_W-1:0] f_product;
    logic [VOLT_BITS-2:0] f_bus;
    logic              f_neg;
    logic              f_zero;

    wvpd_front #(
        .VOLT_BITS (VOLT_BITS),
        .DUTY_BITS (DUTY_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (sample.valid),
        .in_ready       (sample.ready),
        .voltage_demand (sample.voltage_demand),
        .bus_voltage    (sample.bus_voltage),
        .full_scale     (full_scale_reg),
        .out_valid      (f_valid),
        .out_ready      (f_ready),
        .product        (f_product),
        .bus            (f_bus),
        .negative       (f_neg),
        .bus_zero       (f_zero)
    );

    // Divider chain. Since the clamped magnitude never exceeds the bus, the
    // quotient never exceeds the full-scale count, so the upper product bits
    // are already below the divisor and only DUTY_BITS steps are needed.
    logic                 d_valid [DUTY_BITS+1];
    logic                 d_ready [DUTY_BITS+1];
    logic [VOLT_BITS-2:0] d_rem   [DUTY_BITS+1];
    logic [DUTY_BITS-1:0] d_low   [DUTY_BITS+1];
    logic [DUTY_BITS-1:0] d_quot  [DUTY_BITS+1];
    logic [VOLT_BITS-2:0] d_bus   [DUTY_BITS+1];
    logic                 d_neg   [DUTY_BITS+1];
    logic                 d_zero  [DUTY_BITS+1];

    assign d_valid[0] = f_valid;
    assign f_ready    = d_ready[0];
    assign d_rem[0]   = f_product[PROD_W-1:DUTY_BITS];
    assign d_low[0]   = f_product[DUTY_BITS-1:0];
    assign d_quot[0]  = '0;
    assign d_bus[0]   = f_bus;
    assign d_neg[0]   = f_neg;
    assign d_zero[0]  = f_zero;

    for (genvar s = 0; s < DUTY_BITS; s++)
    begin : g_div
        wvpd_div_step #(
            .VOLT_BITS (VOLT_BITS),
            .DUTY_BITS (DUTY_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (d_valid[s]),
            .up_ready (d_ready[s]),
            .up_rem   (d_rem[s]),
            .up_low   (d_low[s]),
            .up_quot  (d_quot[s]),
            .up_bus   (d_bus[s]),
            .up_neg   (d_neg[s]),
            .up_zero  (d_zero[s]),
            .dn_valid (d_valid[s+1]),
            .dn_ready (d_ready[s+1]),
            .dn_rem   (d_rem[s+1]),
            .dn_low   (d_low[s+1]),
            .dn_quot  (d_quot[s+1]),
            .dn_bus   (d_bus[s+1]),
            .dn_neg   (d_neg[s+1]),
            .dn_zero  (d_zero[s+1])
        );
    end

    // The last step's remainder, leftover bits and divisor are not needed;
    // the output stage takes the quotient, sign and zero-bus flag.
    wvpd_back #(
        .DUTY_BITS (DUTY_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .up_valid       (d_valid[DUTY_BITS]),
        .up_ready       (d_ready[DUTY_BITS]),
        .quotient       (d_quot[DUTY_BITS]),
        .negative       (d_neg[DUTY_BITS]),
        .bus_zero       (d_zero[DUTY_BITS]),
        .full_scale     (full_scale_reg),
        .minimum        (minimum_reg),
        .dn_valid       (duty.valid),
        .dn_ready       (duty.ready),
        .duty_magnitude (duty.duty_magnitude),
        .reverse_drive  (duty.reverse_drive)
    );

endmodule : winding_voltage_to_pwm_duty

`default_nettype wire

// File: design/wvpd_front.sv
// ----------------------------------------------------------------------------
// wvpd_front
// Two pipeline stages: magnitude and clamp of the demand, then the multiply
// by the full-scale duty count.
// ----------------------------------------------------------------------------
`default_nettype none

module wvpd_front #(
    parameter int VOLT_BITS = wvpd_pkg::VOLT_BITS_DEF,
    parameter int DUTY_BITS = wvpd_pkg::DUTY_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [VOLT_BITS-1:0]    voltage_demand,
    input  wire logic [VOLT_BITS-2:0]           bus_voltage,
    input  wire logic [DUTY_BITS-1:0]           full_scale,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [VOLT_BITS+DUTY_BITS-2:0]      product,
    output logic [VOLT_BITS-2:0]                bus,
    output logic                                negative,
    output logic                                bus_zero
);
    localparam int PROD_W = VOLT_BITS + DUTY_BITS - 1;

    logic                 a_valid_reg;
    logic [VOLT_BITS-2:0] a_mag_reg;
    logic [VOLT_BITS-2:0] a_bus_reg;
    logic                 a_neg_reg;
    logic                 a_ready;

    logic                 b_valid_reg;
    logic [PROD_W-1:0]    b_prod_reg;
    logic [VOLT_BITS-2:0] b_bus_reg;
    logic                 b_neg_reg;
    logic                 b_zero_reg;
    logic                 b_ready;

    logic [VOLT_BITS-1:0] abs_demand;
    logic [VOLT_BITS-2:0] a_mag_next;
    logic [PROD_W-1:0]    b_prod_next;

    // The magnitude of the most negative demand still fits the unsigned width.
    always_comb
    begin
        if (voltage_demand[VOLT_BITS-1])
        begin
            abs_demand = VOLT_BITS'(-voltage_demand);
        end
        else
        begin
            abs_demand = VOLT_BITS'(voltage_demand);
        end
        if (abs_demand > {1'b0, bus_voltage})
        begin
            a_mag_next = bus_voltage;
        end
        else
        begin
            a_mag_next = abs_demand[VOLT_BITS-2:0];
        end
    end

    assign b_prod_next = PROD_W'(a_mag_reg) * PROD_W'(full_scale);

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_mag_reg <= a_mag_next;
            a_bus_reg <= bus_voltage;
            a_neg_reg <= voltage_demand[VOLT_BITS-1];
        end
        if (b_ready && a_valid_reg)
        begin
            b_prod_reg <= b_prod_next;
            b_bus_reg  <= a_bus_reg;
            b_neg_reg  <= a_neg_reg;
            b_zero_reg <= (a_bus_reg == '0);
        end
    end

    assign out_valid = b_valid_reg;
    assign product   = b_prod_reg;
    assign bus       = b_bus_reg;
    assign negative  = b_neg_reg;
    assign bus_zero  = b_zero_reg;

endmodule : wvpd_front

`default_nettype wire

// File: design/wvpd_div_step.sv
// ----------------------------------------------------------------------------
// wvpd_div_step
// One registered step of the restoring divider: develops one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module wvpd_div_step #(
    parameter int VOLT_BITS = wvpd_pkg::VOLT_BITS_DEF,
    parameter int DUTY_BITS = wvpd_pkg::DUTY_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire logic [VOLT_BITS-2:0] up_rem,
    input  wire logic [DUTY_BITS-1:0] up_low,
    input  wire logic [DUTY_BITS-1:0] up_quot,
    input  wire logic [VOLT_BITS-2:0] up_bus,
    input  wire logic                 up_neg,
    input  wire logic                 up_zero,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output logic [VOLT_BITS-2:0]      dn_rem,
    output logic [DUTY_BITS-1:0]      dn_low,
    output logic [DUTY_BITS-1:0]      dn_quot,
    output logic [VOLT_BITS-2:0]      dn_bus,
    output logic                      dn_neg,
    output logic                      dn_zero
);
    logic                 valid_reg;
    logic [VOLT_BITS-2:0] rem_reg;
    logic [DUTY_BITS-1:0] low_reg;
    logic [DUTY_BITS-1:0] quot_reg;
    logic [VOLT_BITS-2:0] bus_reg;
    logic                 neg_reg;
    logic                 zero_reg;

    logic [VOLT_BITS-1:0] trial;
    logic [VOLT_BITS-1:0] diff;
    logic                 fits;
    logic [VOLT_BITS-2:0] rem_next;

    // The partial remainder stays below the divisor, so it keeps its width.
    assign trial    = {up_rem, up_low[DUTY_BITS-1]};
    assign diff     = trial - {1'b0, up_bus};
    assign fits     = (trial >= {1'b0, up_bus});
    assign rem_next = fits ? diff[VOLT_BITS-2:0] : trial[VOLT_BITS-2:0];

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {up_low[DUTY_BITS-2:0], 1'b0};
            quot_reg <= {up_quot[DUTY_BITS-2:0], fits};
            bus_reg  <= up_bus;
            neg_reg  <= up_neg;
            zero_reg <= up_zero;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_low   = low_reg;
    assign dn_quot  = quot_reg;
    assign dn_bus   = bus_reg;
    assign dn_neg   = neg_reg;
    assign dn_zero  = zero_reg;

endmodule : wvpd_div_step

`default_nettype wire

// File: design/wvpd_back.sv
// ----------------------------------------------------------------------------
// wvpd_back
// Output stage: zero-bus handling, saturation, direction and minimum duty.
// ----------------------------------------------------------------------------
`default_nettype none

module wvpd_back #(
    parameter int DUTY_BITS = wvpd_pkg::DUTY_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire logic [DUTY_BITS-1:0] quotient,
    input  wire logic                 negative,
    input  wire logic                 bus_zero,
    input  wire logic [DUTY_BITS-1:0] full_scale,
    input  wire logic [DUTY_BITS-1:0] minimum,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output logic [DUTY_BITS-1:0]      duty_magnitude,
    output logic                      reverse_drive
);
    logic                 valid_reg;
    logic [DUTY_BITS-1:0] duty_reg;
    logic                 reverse_reg;

    logic [DUTY_BITS-1:0] raw_duty;
    logic [DUTY_BITS-1:0] sat_duty;
    logic [DUTY_BITS-1:0] duty_next;
    logic                 reverse_next;

    always_comb
    begin
        raw_duty     = bus_zero ? '0 : quotient;
        sat_duty     = (raw_duty > full_scale) ? full_scale : raw_duty;
        // A duty that truncates to zero always drives forward.
        reverse_next = negative && (sat_duty != '0);
        duty_next    = (sat_duty < minimum) ? minimum : sat_duty;
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            duty_reg    <= duty_next;
            reverse_reg <= reverse_next;
        end
    end

    assign dn_valid       = valid_reg;
    assign duty_magnitude = duty_reg;
    assign reverse_drive  = reverse_reg;

endmodule : wvpd_back

`default_nettype wire

// File: design/wvpd_checker.sv
// ----------------------------------------------------------------------------
// wvpd_checker
// Port-level assertions for the winding voltage to PWM duty converter.
// ----------------------------------------------------------------------------
`default_nettype none

module wvpd_checker #(
    parameter int DUTY_BITS = wvpd_pkg::DUTY_BITS_DEF
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 duty_valid,
    input wire logic                 duty_ready,
    input wire logic [DUTY_BITS-1:0] duty_magnitude,
    input wire logic                 reverse_drive,
    input wire logic                 cfg_valid,
    input wire logic                 cfg_ready
);
    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid && !duty_ready |=> duty_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid && !duty_ready |=> $stable(duty_magnitude) && $stable(reverse_drive))
        else $error("result changed while stalled");

    // Reverse drive is only reported for a nonzero duty.
    a_reverse_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        duty_valid && reverse_drive |-> duty_magnitude != '0)
        else $error("reverse drive with zero duty");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule : wvpd_checker

bind winding_voltage_to_pwm_duty wvpd_checker #(
    .DUTY_BITS (DUTY_BITS)
) u_wvpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .duty_valid     (duty.valid),
    .duty_ready     (duty.ready),
    .duty_magnitude (duty.duty_magnitude),
    .reverse_drive  (duty.reverse_drive),
    .cfg_valid      (cfg.valid),
    .cfg_ready      (cfg.ready)
);

`default_nettype wire

// File: tb/wvpd_duty_checker.sv
// ----------------------------------------------------------------------------
// wvpd_duty_checker
// Watches the sample, duty and configuration channels of the converter. It
// predicts the duty word for every accepted sample and compares it, field by
// field, with the duty words that the block hands out, in order.
// ----------------------------------------------------------------------------
module wvpd_duty_checker (
    input  logic clk,
    input  logic rst_n,
    wvpd_in_if   sample,
    wvpd_out_if  duty,
    wvpd_cfg_if  cfg,
    output int   mismatches,
    output int   outstanding
);

    localparam int VB = wvpd_pkg::VOLT_BITS_DEF;
    localparam int DB = wvpd_pkg::DUTY_BITS_DEF;

    typedef struct packed {
        logic [DB-1:0] magnitude;
        logic          reverse;
    } duty_word_t;

    // Local copy of the scaling registers.
    longint full_scale = wvpd_pkg::FULL_SCALE_RESET;
    longint minimum    = wvpd_pkg::MINIMUM_RESET;

    duty_word_t expected_duty_q[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("[%0t] duty check: %s", $time, msg);
    endtask

    // Clamp the demand to the bus, scale it to a duty count truncated toward
    // zero, saturate, and raise the magnitude to the minimum.
    function automatic duty_word_t demand_to_duty(input logic signed [VB-1:0] demand,
                                                  input logic [VB-2:0] bus);
        longint     volts;
        longint     level;
        longint     rail;
        longint     count;
        bit         negative;
        duty_word_t word;
        volts    = demand;
        rail     = bus;
        negative = volts < 0;
        level    = negative ? -volts : volts;
        if (level > rail)
            level = rail;
        count = (rail == 0) ? 0 : (level * full_scale) / rail;
        if (count > full_scale)
            count = full_scale;
        if (count == 0)
            negative = 1'b0;
        if (count < minimum)
            count = minimum;
        word.magnitude = count[DB-1:0];
        word.reverse   = negative;
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        duty_word_t want;
        if (!rst_n)
        begin
            expected_duty_q.delete();
            full_scale = wvpd_pkg::FULL_SCALE_RESET;
            minimum    = wvpd_pkg::MINIMUM_RESET;
        end
        else
        begin
            if (duty.valid === 1'b1 && duty.ready === 1'b1)
            begin
                if (expected_duty_q.size() == 0)
                    note_mismatch($sformatf("unexpected duty word %0d/%0b",
                                            duty.duty_magnitude, duty.reverse_drive));
                else
                begin
                    want = expected_duty_q.pop_front();
                    if (duty.duty_magnitude !== want.magnitude)
                        note_mismatch($sformatf("duty_magnitude %0d, expected %0d",
                                                duty.duty_magnitude, want.magnitude));
                    if (duty.reverse_drive !== want.reverse)
                        note_mismatch($sformatf("reverse_drive %0b, expected %0b",
                                                duty.reverse_drive, want.reverse));
                end
            end
            if (sample.valid === 1'b1 && sample.ready === 1'b1)
                expected_duty_q.push_back(demand_to_duty(sample.voltage_demand,
                                                         sample.bus_voltage));
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
            begin
                if (cfg.index == wvpd_pkg::REG_FULL_SCALE)
                    full_scale = cfg.data;
                else if (cfg.index == wvpd_pkg::REG_MINIMUM)
                    minimum = cfg.data;
            end
        end
        outstanding = expected_duty_q.size();
    end

endmodule : wvpd_duty_checker

// File: tb/winding_voltage_to_pwm_duty_test.sv
// ----------------------------------------------------------------------------
// winding_voltage_to_pwm_duty_test
// Drives voltage demands and bus voltages into the duty converter under a
// series of scaling settings, with random idle cycles on both channels, and
// lets a checker compare every duty word with its own prediction.
// ----------------------------------------------------------------------------
module winding_voltage_to_pwm_duty_test;

    localparam int VOLT_W = wvpd_pkg::VOLT_BITS_DEF;
    localparam int DUTY_W = wvpd_pkg::DUTY_BITS_DEF;
    localparam int BUS_W  = VOLT_W - 1;

    // Pipeline depth given for the block: clamp, multiply, one stage per
    // quotient bit, and the output stage.
    localparam int LATENCY      = DUTY_W + 3;
    localparam int PHASES       = 8;
    localparam int PER_PHASE    = 215;
    localparam int IDLE_PERCENT = 26;
    localparam logic [BUS_W-1:0] BUS_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;

    // While this is set neither side inserts idle cycles.
    bit   calm;

    wvpd_in_if  sample_ch ();
    wvpd_out_if duty_ch ();
    wvpd_cfg_if cfg_ch ();

    winding_voltage_to_pwm_duty u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .duty   (duty_ch),
        .cfg    (cfg_ch)
    );

    wvpd_duty_checker u_duty_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .duty        (duty_ch),
        .cfg         (cfg_ch),
        .mismatches  (fail_count),
        .outstanding (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on the run, far beyond the slowest correct run with the
    // idle rates used here.
    initial
    begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

    // The duty side stalls at random except during the calm phase. Like all
    // other inputs, ready changes only on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
            duty_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Presents one sample, possibly after a few idle cycles, and returns at
    // the falling edge after its transfer. Valid is left high so that the
    // next sample can follow back to back without a gap.
    task automatic offer_sample(input logic signed [VOLT_W-1:0] demand,
                                input logic [BUS_W-1:0] bus);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.voltage_demand <= demand;
        sample_ch.bus_voltage    <= bus;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random sample. Most demands fall within the bus so that the whole duty
    // range is covered; the rest are raw 24-bit values, the extremes, or tiny
    // magnitudes that truncate to a zero duty. The bus is sometimes zero,
    // sometimes at its maximum, sometimes very small.
    task automatic offer_random_sample();
        logic [BUS_W-1:0]         bus;
        logic signed [VOLT_W-1:0] demand;
        int                       level;
        case ($urandom_range(0, 9))
            0:       bus = '0;
            1:       bus = BUS_MAX;
            2:       bus = BUS_W'($urandom_range(1, 255));
            default: bus = BUS_W'($urandom_range(1, BUS_MAX));
        endcase
        case ($urandom_range(0, 9))
            0:       demand = VOLT_W'($urandom);
            1:       demand = $urandom_range(0, 1) ? {1'b0, {(VOLT_W-1){1'b1}}}
                                                   : {1'b1, {(VOLT_W-1){1'b0}}};
            2:
            begin
                demand = VOLT_W'($urandom_range(0, 15));
                if ($urandom_range(0, 1))
                    demand = -demand;
            end
            default:
            begin
                level  = $urandom_range(0, int'(bus));
                demand = VOLT_W'(level);
                if ($urandom_range(0, 1))
                    demand = -demand;
            end
        endcase
        offer_sample(demand, bus);
    endtask

    // Writes full scale and then the minimum in two back-to-back transfers.
    task automatic load_scaling(input logic [DUTY_W-1:0] full_scale,
                                input logic [DUTY_W-1:0] minimum);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= wvpd_pkg::REG_FULL_SCALE;
        cfg_ch.data  <= full_scale;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.index <= wvpd_pkg::REG_MINIMUM;
        cfg_ch.data  <= minimum;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stops the sample stream and waits until every duty word is back, so that
    // the registers change on an idle block.
    task automatic drain_pipeline();
        sample_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    initial
    begin
        logic [DUTY_W-1:0] full_scale;
        logic [DUTY_W-1:0] minimum;
        int                waited;

        // Every input known from time zero; reset released on a falling edge.
        rst_n                    = 1'b0;
        calm                     = 1'b0;
        sample_ch.valid          = 1'b0;
        sample_ch.voltage_demand = '0;
        sample_ch.bus_voltage    = '0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.index             = wvpd_pkg::REG_FULL_SCALE;
        cfg_ch.data              = '0;
        duty_ch.ready            = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed samples under the reset scaling (full scale 2000, no
        // minimum). They hit the field extremes, a zero bus with either sign
        // of demand, clamping on both sides, and small negative demands on
        // either side of the point where the duty truncates to zero and the
        // direction has to stay forward.
        offer_sample(24'sd8388607, BUS_MAX);
        offer_sample(-24'sd8388608, BUS_MAX);
        offer_sample(24'sd0, BUS_MAX);
        offer_sample(24'sd0, 23'd0);
        offer_sample(24'sd8388607, 23'd0);
        offer_sample(-24'sd8388608, 23'd0);
        offer_sample(-24'sd1, BUS_MAX);
        offer_sample(24'sd1, BUS_MAX);
        offer_sample(-24'sd4194, BUS_MAX);
        offer_sample(-24'sd4195, BUS_MAX);
        offer_sample(24'sd65536, 23'd32768);
        offer_sample(-24'sd65536, 23'd32768);
        offer_sample(24'sd32768, 23'd32768);
        offer_sample(-24'sd32768, 23'd32768);
        offer_sample(24'sd16384, 23'd32768);
        offer_sample(-24'sd16384, 23'd32768);
        offer_sample(24'sd1, 23'd1);
        offer_sample(-24'sd1, 23'd1);
        offer_sample(24'sd12345, 23'd7);
        offer_sample(-24'sd8388607, BUS_MAX);
        offer_sample(24'sd5592405, BUS_MAX);

        // Random phases, each under its own scaling: the largest and the
        // smallest full scale, a zero full scale, a typical setting with a
        // minimum, a minimum above full scale, a random pair, both registers
        // at their maximum, and back to the reset values. The fourth phase
        // runs with no idle cycles on either side.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin full_scale = 15'd32767; minimum = 15'd0;     end
                1:       begin full_scale = 15'd1;     minimum = 15'd0;     end
                2:       begin full_scale = 15'd0;     minimum = 15'd0;     end
                3:       begin full_scale = 15'd2000;  minimum = 15'd100;   end
                4:       begin full_scale = 15'd100;   minimum = 15'd32767; end
                5:
                begin
                    full_scale = DUTY_W'($urandom_range(1, 32767));
                    minimum    = DUTY_W'($urandom_range(0, int'(full_scale)));
                end
                6:       begin full_scale = 15'd32767; minimum = 15'd32767; end
                default: begin full_scale = 15'd2000;  minimum = 15'd0;     end
            endcase
            drain_pipeline();
            load_scaling(full_scale, minimum);
            calm = (phase == 3);
            repeat (PER_PHASE) offer_random_sample();
        end
        calm = 1'b0;

        // Wait for the last duty words, within a bound, then a little longer
        // to catch anything extra that the block might still hand out.
        sample_ch.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (2 * LATENCY) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule : winding_voltage_to_pwm_duty_test
